// File: sv/ptt_pkg.sv
package ptt_pkg;

	// field widths
	localparam int OFFSET_BITS_DEF = 12;
	localparam int GAIN_W          = 16;
	localparam int LIM_W           = 6;
	localparam int DZ_W            = 8;
	localparam int SPEED_W         = 7;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 16;
	localparam int FRAC_BITS       = 12;

	// clamp constants
	localparam int D_LIMIT    = 8;
	localparam int COMMON_MIN = 5;
	localparam int COMMON_MAX = 50;

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_P_RST   = 16'd819;
	localparam logic [GAIN_W-1:0] GAIN_D_RST   = 16'd328;
	localparam logic [LIM_W-1:0]  COMMON_RST   = 6'd20;
	localparam logic [LIM_W-1:0]  AXIS_X_RST   = 6'd20;
	localparam logic [LIM_W-1:0]  AXIS_Y_RST   = 6'd18;
	localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 8'd0;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_X     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_Y     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_X     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_Y     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COMMON_LIMIT = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_LIMIT_X = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_LIMIT_Y = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE    = 4'd7;

	// settings seen by the datapath, limits already resolved
	typedef struct packed {
		logic [GAIN_W-1:0] gain_p_x;
		logic [GAIN_W-1:0] gain_p_y;
		logic [GAIN_W-1:0] gain_d_x;
		logic [GAIN_W-1:0] gain_d_y;
		logic [LIM_W-1:0]  lim_x;
		logic [LIM_W-1:0]  lim_y;
		logic [DZ_W-1:0]   dead_zone;
	} ptt_cfg_t;

endpackage

// File: sv/per_axis_pd_target_tracking_core.sv
// An accepted item is held in the input register, and its result is loaded from there
// into the output register once the output register can advance.
// Throughput: one item per cycle; the input register and the output register
// together hold two items, so input stalls only when both are full and out_stall is high.
// Reset (arst_n low): pipeline empty, previous errors zero, not seeded,
// registers at their documented reset values.
module per_axis_pd_target_tracking_core #(
	parameter int OFFSET_BITS = ptt_pkg::OFFSET_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ptt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ptt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [OFFSET_BITS-1:0]      offset_x,
	input  logic signed [OFFSET_BITS-1:0]      offset_y,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ptt_pkg::SPEED_W-1:0] speed_x,
	output logic signed [ptt_pkg::SPEED_W-1:0] speed_y
);
	import ptt_pkg::*;

	ptt_cfg_t cfg;

	logic                          valid_s1;
	logic signed [OFFSET_BITS-1:0] off_x_s1, off_y_s1;
	logic signed [OFFSET_BITS-1:0] prev_x_q, prev_y_q;
	logic                          seeded_q;
	logic                          out_valid_q;
	logic signed [SPEED_W-1:0]     speed_x_q, speed_y_q;
	logic signed [OFFSET_BITS-1:0] err_x, err_y;
	logic signed [SPEED_W-1:0]     spd_x, spd_y;
	logic                          adv_out, in_fire, mv;

	ptt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake
	assign adv_out  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_out;
	assign in_fire  = in_valid && !in_stall;
	assign mv       = valid_s1 && adv_out;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !adv_out);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			off_x_s1 <= offset_x;
			off_y_s1 <= offset_y;
		end
	end

	// per-axis datapath
	ptt_axis #(.OFFSET_BITS(OFFSET_BITS)) u_axis_x (
		.offset    (off_x_s1),
		.prev_err  (prev_x_q),
		.seeded    (seeded_q),
		.gain_p    (cfg.gain_p_x),
		.gain_d    (cfg.gain_d_x),
		.lim       (cfg.lim_x),
		.dead_zone (cfg.dead_zone),
		.err       (err_x),
		.speed     (spd_x)
	);

	ptt_axis #(.OFFSET_BITS(OFFSET_BITS)) u_axis_y (
		.offset    (off_y_s1),
		.prev_err  (prev_y_q),
		.seeded    (seeded_q),
		.gain_p    (cfg.gain_p_y),
		.gain_d    (cfg.gain_d_y),
		.lim       (cfg.lim_y),
		.dead_zone (cfg.dead_zone),
		.err       (err_y),
		.speed     (spd_y)
	);

	// tracking state, cleared when a centered item passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			seeded_q <= 1'b0;
		end else if (mv) begin
			prev_x_q <= err_x;
			prev_y_q <= err_y;
			seeded_q <= !((err_x == '0) && (err_y == '0));
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv) begin
			speed_x_q <= spd_x;
			speed_y_q <= spd_y;
		end
	end

	assign out_valid = out_valid_q;
	assign speed_x   = speed_x_q;
	assign speed_y   = speed_y_q;

	// input only stalls when both stages are full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with free room");

	// an item leaving the input register always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		mv |=> out_valid_q)
		else $error("item lost between stages");

	// results stay within the effective axis limits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (($signed({speed_x_q[SPEED_W-1], speed_x_q}) <=
			$signed({2'b00, cfg.lim_x})) &&
			($signed({speed_x_q[SPEED_W-1], speed_x_q}) >=
			-$signed({2'b00, cfg.lim_x}))))
		else $error("speed_x beyond limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (($signed({speed_y_q[SPEED_W-1], speed_y_q}) <=
			$signed({2'b00, cfg.lim_y})) &&
			($signed({speed_y_q[SPEED_W-1], speed_y_q}) >=
			-$signed({2'b00, cfg.lim_y}))))
		else $error("speed_y beyond limit");

endmodule

// File: sv/ptt_cfg.sv
module ptt_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ptt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptt_pkg::CFG_DATA_W-1:0]    cfg_data,
	output ptt_pkg::ptt_cfg_t                 cfg
);
	import ptt_pkg::*;

	logic [GAIN_W-1:0] gain_p_x_q, gain_p_y_q, gain_d_x_q, gain_d_y_q;
	logic [LIM_W-1:0]  common_q, axis_x_q, axis_y_q;
	logic [DZ_W-1:0]   dead_zone_q;
	logic [LIM_W-1:0]  com_c;

	assign cfg_ready = 1'b1;

	// register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_x_q  <= GAIN_P_RST;
			gain_p_y_q  <= GAIN_P_RST;
			gain_d_x_q  <= GAIN_D_RST;
			gain_d_y_q  <= GAIN_D_RST;
			common_q    <= COMMON_RST;
			axis_x_q    <= AXIS_X_RST;
			axis_y_q    <= AXIS_Y_RST;
			dead_zone_q <= DEAD_ZONE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_P_X:     gain_p_x_q  <= cfg_data;
				REG_GAIN_P_Y:     gain_p_y_q  <= cfg_data;
				REG_GAIN_D_X:     gain_d_x_q  <= cfg_data;
				REG_GAIN_D_Y:     gain_d_y_q  <= cfg_data;
				REG_COMMON_LIMIT: common_q    <= cfg_data[LIM_W-1:0];
				REG_AXIS_LIMIT_X: axis_x_q    <= cfg_data[LIM_W-1:0];
				REG_AXIS_LIMIT_Y: axis_y_q    <= cfg_data[LIM_W-1:0];
				REG_DEAD_ZONE:    dead_zone_q <= cfg_data[DZ_W-1:0];
				default: ;
			endcase
		end
	end

	// shared limit held to its legal band, then min with each axis limit
	always_comb begin
		if (common_q < LIM_W'(COMMON_MIN))
			com_c = LIM_W'(COMMON_MIN);
		else if (common_q > LIM_W'(COMMON_MAX))
			com_c = LIM_W'(COMMON_MAX);
		else
			com_c = common_q;
	end

	assign cfg.gain_p_x  = gain_p_x_q;
	assign cfg.gain_p_y  = gain_p_y_q;
	assign cfg.gain_d_x  = gain_d_x_q;
	assign cfg.gain_d_y  = gain_d_y_q;
	assign cfg.lim_x     = (axis_x_q < com_c) ? axis_x_q : com_c;
	assign cfg.lim_y     = (axis_y_q < com_c) ? axis_y_q : com_c;
	assign cfg.dead_zone = dead_zone_q;

endmodule

// File: sv/ptt_axis.sv
module ptt_axis #(
	parameter int OFFSET_BITS = ptt_pkg::OFFSET_BITS_DEF
) (
	input  logic signed [OFFSET_BITS-1:0]     offset,
	input  logic signed [OFFSET_BITS-1:0]     prev_err,
	input  logic                              seeded,
	input  logic [ptt_pkg::GAIN_W-1:0]        gain_p,
	input  logic [ptt_pkg::GAIN_W-1:0]        gain_d,
	input  logic [ptt_pkg::LIM_W-1:0]         lim,
	input  logic [ptt_pkg::DZ_W-1:0]          dead_zone,
	output logic signed [OFFSET_BITS-1:0]     err,
	output logic signed [ptt_pkg::SPEED_W-1:0] speed
);
	import ptt_pkg::*;

	localparam int W  = OFFSET_BITS;
	localparam int CW = W + DZ_W;
	localparam int PW = W + GAIN_W;
	localparam int DW = W + 1 + GAIN_W;
	localparam int SW = W + 6;

	logic [W-1:0]           in_mag;
	logic [W-1:0]           err_mag;
	logic signed [W:0]      diff;
	logic [W:0]             diff_mag;
	logic [PW-1:0]          p_prod;
	logic [DW-1:0]          d_prod;
	logic [PW-FRAC_BITS-1:0] p_mag;
	logic [DW-FRAC_BITS-1:0] d_mag;
	logic [DW-FRAC_BITS-1:0] d_mag_c;
	logic signed [SW-1:0]   p_s, d_s, sum, lim_s, sum_c;

	// deadband on the raw offset
	assign in_mag = offset[W-1] ? W'(-offset) : W'(offset);
	assign err    = (CW'(in_mag) <= CW'(dead_zone)) ? '0 : offset;

	// error change, zero on an unseeded sample
	assign diff     = seeded ? ($signed({err[W-1], err}) - $signed({prev_err[W-1], prev_err}))
	                         : '0;
	assign diff_mag = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
	assign err_mag  = err[W-1] ? W'(-err) : W'(err);

	// sign-magnitude products, truncated toward zero
	assign p_prod = PW'(err_mag) * PW'(gain_p);
	assign d_prod = DW'(diff_mag) * DW'(gain_d);
	assign p_mag  = p_prod[PW-1:FRAC_BITS];
	assign d_mag  = d_prod[DW-1:FRAC_BITS];

	// derivative term clamp
	assign d_mag_c = (d_mag > (DW-FRAC_BITS)'(D_LIMIT)) ? (DW-FRAC_BITS)'(D_LIMIT) : d_mag;

	assign p_s = err[W-1] ? -$signed(SW'(p_mag)) : $signed(SW'(p_mag));
	assign d_s = diff[W] ? -$signed(SW'(d_mag_c)) : $signed(SW'(d_mag_c));

	// sum and output clamp
	assign sum   = p_s + d_s;
	assign lim_s = $signed(SW'(lim));
	always_comb begin
		if (sum > lim_s)
			sum_c = lim_s;
		else if (sum < -lim_s)
			sum_c = -lim_s;
		else
			sum_c = sum;
	end

	assign speed = sum_c[SPEED_W-1:0];

endmodule
